/* hw/rtl/pdv_pkg.sv */
// Package with the shared types and constants of the perspective divide block.
package pdv_pkg;

    // Register indexes on the configuration channel.
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_WIDTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_HEIGHT = 8'd1;
    localparam logic [12:0] VIEWPORT_WIDTH_RESET = 13'd640;
    localparam logic [12:0] VIEWPORT_HEIGHT_RESET = 13'd480;

    // Screen coordinates beyond this magnitude in 12.4 units are rejected.
    localparam logic [31:0] SCREEN_LIMIT = 32'd16384;

    // Divider geometry: 32 quotient bits, two per stage.
    localparam int unsigned QUOT_W = 32;
    localparam int unsigned NUM_W = 50;
    localparam int unsigned REM_W = 64;
    localparam int unsigned BITS_PER_STAGE = 2;
    localparam int unsigned DIV_STAGES = QUOT_W / BITS_PER_STAGE;
    localparam int unsigned LANES = 4;

    // Lanes of the divider.
    localparam int unsigned LANE_X = 0;
    localparam int unsigned LANE_Y = 1;
    localparam int unsigned LANE_Z = 2;
    localparam int unsigned LANE_INV = 3;

    // Pipeline depth: sums, products, setup, divider stages, output.
    localparam int unsigned NUM_STAGES = DIV_STAGES + 4;

    // One divider stage: partial remainders and quotients of all lanes.
    typedef struct packed {
        logic [LANES-1:0][REM_W-1:0]  rem;
        logic [LANES-1:0][QUOT_W-1:0] quot;
        logic [LANES-1:0]             neg;
        logic [LANES-1:0]             ovf;
        logic [31:0]                  dmag;
        logic                         wzero;
    } div_t;

endpackage

/* hw/rtl/pdv_if.sv */
// Channel interfaces: vertex input, pixel output and configuration write.
interface pdv_vertex_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] clip_x;
    logic signed [31:0] clip_y;
    logic signed [31:0] clip_z;
    logic signed [31:0] clip_w;

    modport source (output valid, clip_x, clip_y, clip_z, clip_w, input ready);
    modport sink (input valid, clip_x, clip_y, clip_z, clip_w, output ready);
endinterface

interface pdv_pixel_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic signed [31:0] depth;
    logic signed [31:0] inv_w;
    logic               reject;

    modport source (output valid, screen_x, screen_y, depth, inv_w, reject, input ready);
    modport sink (input valid, screen_x, screen_y, depth, inv_w, reject, output ready);
endinterface

interface pdv_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pdv_pkg::CFG_IDX_W-1:0]  index;
    logic [pdv_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/perspective_divide_viewport.sv */
// Perspective divide and viewport transform, one vertex per beat.
//
// Channels: "vertex" carries a clip-space vertex (x, y, z, w, signed Q16.16),
// "pixel" carries screen x and y (signed 12.4), depth and 1/w (signed Q16.16)
// and a reject flag. "cfg" writes viewport width (index 0) and height
// (index 1); it is always ready. The user must write it only while the block
// is idle; the block itself does not enforce this. Throughput is one vertex
// per cycle while the pixel receiver is ready: the four divisions run in a
// pipelined restoring divider that resolves two quotient bits per stage over
// 16 stages. Every stage holds its own valid bit and loads when it is empty
// or when the stage after it moves, so bubbles close up and a stalled receiver
// fills the pipeline before vertex.ready drops; nothing is lost or repeated.
// Reset clears all valid bits and sets the viewport to 640 by 480.
// A vertex with w equal to zero, or whose screen position lies outside
// plus or minus 16384, is rejected with screen x and y forced to zero.
module perspective_divide_viewport (
    input  logic         clk,
    input  logic         rst_n,
    pdv_vertex_if.sink   vertex,
    pdv_pixel_if.source  pixel,
    pdv_cfg_if.sink      cfg
);
    import pdv_pkg::*;

    // One restoring step pair on all lanes, quotient bits j and j-1.
    function automatic div_t div_step(input div_t s, input int unsigned k);
        div_t                   r;
        logic [REM_W-1:0]       dd;
        int unsigned            j;
        r = s;
        for (int l = 0; l < LANES; l++) begin
            for (int b = 0; b < BITS_PER_STAGE; b++) begin
                j = QUOT_W - 1 - k * BITS_PER_STAGE - b;
                dd = {32'd0, s.dmag} << j;
                if (r.rem[l] >= dd) begin
                    r.rem[l] = r.rem[l] - dd;
                    r.quot[l][j] = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Configuration registers.
    logic [12:0] vw_reg;
    logic [12:0] vh_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vw_reg <= VIEWPORT_WIDTH_RESET;
            vh_reg <= VIEWPORT_HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_VIEWPORT_WIDTH)
                vw_reg <= cfg.data[12:0];
            else if (cfg.index == REG_VIEWPORT_HEIGHT)
                vh_reg <= cfg.data[12:0];
        end
    end

    // Valid bits, one per stage, and the ready chain, which also holds pixel.ready at its top.
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;
    logic [NUM_STAGES:0]   rdy;

    assign rdy[NUM_STAGES] = pixel.ready;
    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_rdy
        assign rdy[i] = !v_reg[i] || rdy[i+1];
    end

    assign vertex.ready = rdy[0];

    always_comb
    begin
        v_next = v_reg;
        if (rdy[0])
            v_next[0] = vertex.valid;
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (rdy[i])
                v_next[i] = v_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    // Stage 0: sums c + w.
    logic signed [32:0] sx_reg;
    logic signed [32:0] sy_reg;
    logic signed [32:0] sz_reg;
    logic signed [31:0] w0_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            sx_reg <= 33'(vertex.clip_x) + 33'(vertex.clip_w);
            sy_reg <= 33'(vertex.clip_y) + 33'(vertex.clip_w);
            sz_reg <= 33'(vertex.clip_z) + 33'(vertex.clip_w);
            w0_reg <= vertex.clip_w;
        end
    end

    // Stage 1: numerators, scaled by viewport size or by one half.
    logic signed [46:0]      px;
    logic signed [46:0]      py;
    logic signed [NUM_W-1:0] nx_reg;
    logic signed [NUM_W-1:0] ny_reg;
    logic signed [NUM_W-1:0] nz_reg;
    logic signed [31:0]      w1_reg;

    assign px = sx_reg * $signed({1'b0, vw_reg});
    assign py = sy_reg * $signed({1'b0, vh_reg});

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            nx_reg <= {px, 3'b000};
            ny_reg <= {py, 3'b000};
            nz_reg <= NUM_W'($signed({sz_reg, 15'd0}));
            w1_reg <= w0_reg;
        end
    end

    // Stage 2: magnitudes, quotient signs and the overflow test.
    div_t                            dv_reg [0:DIV_STAGES];
    div_t                            setup;
    logic [LANES-1:0][NUM_W-1:0]     nmag;
    logic [LANES-1:0]                nsgn;
    logic [31:0]                     dmag;

    always_comb
    begin
        dmag = w1_reg[31] ? 32'(-w1_reg) : 32'(w1_reg);
        nsgn[LANE_X] = nx_reg[NUM_W-1];
        nsgn[LANE_Y] = ny_reg[NUM_W-1];
        nsgn[LANE_Z] = nz_reg[NUM_W-1];
        nsgn[LANE_INV] = 1'b0;
        nmag[LANE_X] = nx_reg[NUM_W-1] ? NUM_W'(-nx_reg) : NUM_W'(nx_reg);
        nmag[LANE_Y] = ny_reg[NUM_W-1] ? NUM_W'(-ny_reg) : NUM_W'(ny_reg);
        nmag[LANE_Z] = nz_reg[NUM_W-1] ? NUM_W'(-nz_reg) : NUM_W'(nz_reg);
        nmag[LANE_INV] = NUM_W'(64'h1_0000_0000);
        setup.dmag = dmag;
        setup.wzero = (w1_reg == '0);
        for (int l = 0; l < LANES; l++)
        begin
            setup.rem[l] = REM_W'(nmag[l]);
            setup.quot[l] = '0;
            setup.neg[l] = nsgn[l] ^ w1_reg[31];
            setup.ovf[l] = REM_W'(nmag[l]) >= {dmag, 32'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
            dv_reg[0] <= setup;
    end

    // Stages 3 to 18: the divider proper.
    for (genvar k = 1; k <= DIV_STAGES; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (rdy[k+2])
                dv_reg[k] <= div_step(dv_reg[k-1], k - 1);
        end
    end

    // Output stage: signs, range test and saturation.
    div_t               fin;
    logic               rej;
    logic signed [15:0] sxo;
    logic signed [15:0] syo;
    logic signed [31:0] dpo;
    logic signed [31:0] ivo;
    logic signed [15:0] sx_out_reg;
    logic signed [15:0] sy_out_reg;
    logic signed [31:0] dp_out_reg;
    logic signed [31:0] iv_out_reg;
    logic               rej_out_reg;

    function automatic logic [31:0] sat_q(input logic [31:0] q, input logic neg,
                                          input logic ovf);
        logic [31:0] r;
        if (!neg)
            r = (ovf || q[31]) ? 32'h7FFF_FFFF : q;
        else
            r = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : -q;
        return r;
    endfunction

    always_comb
    begin
        fin = dv_reg[DIV_STAGES];
        rej = fin.wzero
            || fin.ovf[LANE_X] || (fin.quot[LANE_X] > SCREEN_LIMIT)
            || fin.ovf[LANE_Y] || (fin.quot[LANE_Y] > SCREEN_LIMIT);
        sxo = fin.neg[LANE_X] ? -fin.quot[LANE_X][15:0] : fin.quot[LANE_X][15:0];
        syo = fin.neg[LANE_Y] ? -fin.quot[LANE_Y][15:0] : fin.quot[LANE_Y][15:0];
        dpo = sat_q(fin.quot[LANE_Z], fin.neg[LANE_Z], fin.ovf[LANE_Z]);
        ivo = sat_q(fin.quot[LANE_INV], fin.neg[LANE_INV], fin.ovf[LANE_INV]);
        if (rej)
        begin
            sxo = '0;
            syo = '0;
        end
        if (fin.wzero)
        begin
            dpo = '0;
            ivo = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NUM_STAGES-1])
        begin
            sx_out_reg <= sxo;
            sy_out_reg <= syo;
            dp_out_reg <= dpo;
            iv_out_reg <= ivo;
            rej_out_reg <= rej;
        end
    end

    assign pixel.valid = v_reg[NUM_STAGES-1];
    assign pixel.screen_x = sx_out_reg;
    assign pixel.screen_y = sy_out_reg;
    assign pixel.depth = dp_out_reg;
    assign pixel.inv_w = iv_out_reg;
    assign pixel.reject = rej_out_reg;

    // A rejected vertex carries zero screen coordinates.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && pixel.reject |-> pixel.screen_x == 0 && pixel.screen_y == 0)
        else $error("rejected vertex with nonzero screen position");

    // An accepted vertex lies within the screen limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && !pixel.reject |->
            pixel.screen_x >= -16'sd16384 && pixel.screen_x <= 16'sd16384 &&
            pixel.screen_y >= -16'sd16384 && pixel.screen_y <= 16'sd16384)
        else $error("accepted vertex outside screen limit");

    // A zero divisor always flags every lane as overflowed.
    assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[2] && dv_reg[0].dmag == '0 |-> dv_reg[0].wzero && (&dv_reg[0].ovf))
        else $error("zero w not flagged as overflow");

    // The last divider stage, holding an item that cannot move, keeps it.
    assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NUM_STAGES-2] && !rdy[NUM_STAGES-1] |=> v_reg[NUM_STAGES-2])
        else $error("stalled item dropped before output stage");

endmodule

/* sim/perspective_divide_viewport_tb.sv */
// Testbench for the perspective divide and viewport block: random and directed vertices.
module perspective_divide_viewport_tb;
    import pdv_pkg::*;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [31:0] cw;
    } vertex_t;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [31:0] dep;
        logic signed [31:0] invw;
        logic               rej;
    } pixel_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 40;

    logic clk;
    logic rst_n;

    pdv_vertex_if vtx ();
    pdv_pixel_if  pix ();
    pdv_cfg_if    cfg ();

    perspective_divide_viewport u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .vertex (vtx.sink),
        .pixel  (pix.source),
        .cfg    (cfg.sink)
    );

    vertex_t     vertex_q[$];
    pixel_t      pixel_expect_q[$];
    logic [12:0] vp_width;
    logic [12:0] vp_height;
    int          error_count;
    int          vertices_sent;
    int          pixels_seen;
    int          rejects_seen;
    int          idle_cycles;
    bit          allow_idle;
    bit          hold_pixels;
    int          send_gap;
    int          recv_gap;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Expected pixel for one vertex under the current viewport.
    function automatic pixel_t project_vertex(input vertex_t v);
        pixel_t p;
        logic signed [63:0] w;
        logic signed [63:0] qx;
        logic signed [63:0] qy;
        p = '0;
        w = v.cw;
        if (w == 0)
        begin
            p.rej = 1'b1;
            return p;
        end
        p.dep = clamp32(((64'(v.cz) + w) * 64'sd32768) / w);
        p.invw = clamp32(64'sh100000000 / w);
        qx = ((64'(v.cx) + w) * $signed({51'd0, vp_width}) * 64'sd8) / w;
        qy = ((64'(v.cy) + w) * $signed({51'd0, vp_height}) * 64'sd8) / w;
        p.rej = (qx < -64'sd16384) || (qx > 64'sd16384) ||
                (qy < -64'sd16384) || (qy > 64'sd16384);
        if (!p.rej)
        begin
            p.sx = qx[15:0];
            p.sy = qy[15:0];
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at pixel %0d: got %h, expected %h",
                 what, pixels_seen, got, want);
        error_count++;
    endtask

    // Vertex driver: predicts on each accepted beat, idles in random bursts while idling is allowed.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx.valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (vtx.valid && vtx.ready)
            begin
                pixel_expect_q.push_back(project_vertex(vertex_q.pop_front()));
                vertices_sent++;
            end
            if (send_gap > 0)
            begin
                vtx.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (vertex_q.size() > (vtx.valid && vtx.ready ? 0 : 0) &&
                     !(vtx.valid && vtx.ready && vertex_q.size() == 0))
            begin
                if (allow_idle && !(vtx.valid && !vtx.ready) &&
                    $urandom_range(0, 9) == 0)
                begin
                    vtx.valid <= 1'b0;
                    send_gap <= $urandom_range(1, 12) - 1;
                end
                else
                begin
                    vtx.valid <= 1'b1;
                    vtx.clip_x <= vertex_q[0].cx;
                    vtx.clip_y <= vertex_q[0].cy;
                    vtx.clip_z <= vertex_q[0].cz;
                    vtx.clip_w <= vertex_q[0].cw;
                end
            end
            else
                vtx.valid <= 1'b0;
        end
    end

    // Pixel monitor: compares each accepted beat with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            pix.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (pix.valid && pix.ready)
            begin
                if (pixel_expect_q.size() == 0)
                    report_mismatch("unexpected pixel beat", 32'd1, 32'd0);
                else
                begin
                    want = pixel_expect_q.pop_front();
                    if (pix.screen_x !== want.sx)
                        report_mismatch("screen_x", 32'(pix.screen_x), 32'(want.sx));
                    if (pix.screen_y !== want.sy)
                        report_mismatch("screen_y", 32'(pix.screen_y), 32'(want.sy));
                    if (pix.depth !== want.dep)
                        report_mismatch("depth", pix.depth, want.dep);
                    if (pix.inv_w !== want.invw)
                        report_mismatch("inv_w", pix.inv_w, want.invw);
                    if (pix.reject !== want.rej)
                        report_mismatch("reject", 32'(pix.reject), 32'(want.rej));
                    rejects_seen += want.rej;
                end
                pixels_seen++;
            end
            if (hold_pixels)
                pix.ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                pix.ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else if (allow_idle && $urandom_range(0, 9) == 0)
            begin
                pix.ready <= 1'b0;
                recv_gap <= $urandom_range(1, 12) - 1;
            end
            else
                pix.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no accepted beat on either channel.
    always @(posedge clk)
    begin
        if ((vtx.valid && vtx.ready) || (pix.valid && pix.ready) || hold_pixels)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress");
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        if (idx == REG_VIEWPORT_WIDTH)
            vp_width = val[12:0];
        else if (idx == REG_VIEWPORT_HEIGHT)
            vp_height = val[12:0];
    endtask

    task automatic wait_idle();
        while (vertex_q.size() != 0 || pixel_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            2: return 32'sh80000000;
            3: return 32'sh7fffffff;
            default: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
        endcase
    endfunction

    task automatic add_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic signed [31:0] z, input logic signed [31:0] w);
        vertex_t v;
        v.cx = x;
        v.cy = y;
        v.cz = z;
        v.cw = w;
        vertex_q.push_back(v);
    endtask

    // Random vertices: mostly in front of the camera and near the view volume.
    task automatic add_random(input int n);
        logic signed [31:0] w;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                w = $signed($urandom_range(32'h4000, 32'h80000));
                if ($urandom_range(0, 4) == 0)
                    w = -w;
                add_vertex($signed($urandom_range(0, 2 * w)) - w,
                           $signed($urandom_range(0, 2 * w)) - w, rand_word(), w);
            end
            else
                add_vertex(rand_word(), rand_word(), rand_word(),
                           $urandom_range(0, 7) == 0 ? 32'sd0 : rand_word());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        vtx.valid = 1'b0;
        vtx.clip_x = '0;
        vtx.clip_y = '0;
        vtx.clip_z = '0;
        vtx.clip_w = '0;
        pix.ready = 1'b0;
        vp_width = VIEWPORT_WIDTH_RESET;
        vp_height = VIEWPORT_HEIGHT_RESET;
        error_count = 0;
        vertices_sent = 0;
        pixels_seen = 0;
        rejects_seen = 0;
        idle_cycles = 0;
        allow_idle = 1'b1;
        hold_pixels = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset viewport, center, edges, w zero, extremes, out of range.
        add_vertex(0, 0, 0, 32'sh10000);
        add_vertex(32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000);
        add_vertex(-32'sh10000, -32'sh10000, -32'sh10000, 32'sh10000);
        add_vertex(32'sh12345, 32'sh777, 32'sh5, 32'sd0);
        add_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        add_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        add_vertex(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sd1);
        add_vertex(32'sh7fffffff, 32'sh80000000, 32'sh80000000, -32'sd1);
        add_vertex(32'sh30000, 0, 0, 32'sh10000);
        add_vertex(0, -32'sh30000, 0, 32'sh10000);
        add_vertex(32'sh8000, -32'sh8000, 32'sh4000, -32'sh10000);
        add_vertex(-1, -1, -1, 32'sd2);
        add_vertex(32'shffff, 32'sh1, 32'sh0, 32'sh80000000);
        wait_idle();

        // Viewport extremes, including the out-of-range sizes.
        write_reg(REG_VIEWPORT_WIDTH, 16'd1);
        write_reg(REG_VIEWPORT_HEIGHT, 16'd4096);
        add_vertex(32'sh10000, 32'sh10000, 0, 32'sh10000);
        add_vertex(-32'sh8000, 32'sh8000, 0, 32'sh10000);
        add_random(60);
        wait_idle();
        write_reg(REG_VIEWPORT_WIDTH, 16'd0);
        write_reg(REG_VIEWPORT_HEIGHT, 16'hffff);
        add_vertex(32'sh10000, 32'sh10000, 0, 32'sh10000);
        add_vertex(0, 0, 0, 32'sh10000);
        add_random(40);
        wait_idle();
        write_reg(8'd7, 16'd99);
        write_reg(REG_VIEWPORT_WIDTH, 16'd4096);
        write_reg(REG_VIEWPORT_HEIGHT, 16'd1);

        // Long receiver stall while vertices keep coming.
        add_random(60);
        hold_pixels = 1'b1;
        repeat (200) @(posedge clk);
        hold_pixels = 1'b0;
        wait_idle();
        write_reg(REG_VIEWPORT_WIDTH, $urandom_range(1, 4096));
        write_reg(REG_VIEWPORT_HEIGHT, $urandom_range(1, 4096));
        add_random(140);
        wait_idle();

        // Final stretch at full rate.
        write_reg(REG_VIEWPORT_WIDTH, 16'd640);
        write_reg(REG_VIEWPORT_HEIGHT, 16'd480);
        allow_idle = 1'b0;
        add_random(100);
        wait_idle();

        $display("covered %0d vertices, %0d pixels, %0d rejected, over six viewports",
                 vertices_sent, pixels_seen, rejects_seen);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/pdv_pkg.sv
hw/rtl/pdv_if.sv
hw/rtl/perspective_divide_viewport.sv
sim/perspective_divide_viewport_tb.sv
